@@ rtl/core/wmb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmb_pkg
// Shared types, constants and level-geometry helpers for the mipmap builder.
// ----------------------------------------------------------------------------
package wmb_pkg;

   localparam int BASE_BITS   = 10;
   localparam int MIN_BITS    = 3;
   localparam int SAMPLE_W    = 16;
   localparam int NLEVELS     = (BASE_BITS >= MIN_BITS) ? (BASE_BITS - MIN_BITS + 1) : 1;
   localparam int ADDR_W      = BASE_BITS + 1;
   localparam int STORE_SIZE  = 1 << (BASE_BITS + 1);
   localparam int LEVEL0_SIZE = 1 << BASE_BITS;
   localparam int LV_W        = (NLEVELS > 1) ? $clog2(NLEVELS) : 1;
   localparam int CNT_W       = BASE_BITS + 1;
   localparam int SUM_W       = SAMPLE_W + 3;

   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_REBUILD = 2'd1,
      KIND_READ    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_REBUILD,
      ST_GAP
   } state_type;

   // start of a level inside the packed store
   function automatic addr_type lvl_offset(input logic [3:0] lv);
      logic [ADDR_W:0] st;
      st = (ADDR_W+1)'(STORE_SIZE);
      return addr_type'(st - (st >> lv));
   endfunction

   // number of samples in a level
   function automatic logic [CNT_W-1:0] lvl_size(input logic [3:0] lv);
      logic [CNT_W-1:0] b;
      b = CNT_W'(LEVEL0_SIZE);
      return b >> lv;
   endfunction

   // requested level clamped to the deepest one
   function automatic logic [3:0] read_level(input logic [3:0] req);
      if (int'(req) >= NLEVELS) return 4'(NLEVELS - 1);
      return req;
   endfunction

   // index bits of the requested level, floored at the minimum
   function automatic logic [4:0] level_bits(input logic [3:0] req);
      if (int'(req) > BASE_BITS - MIN_BITS) return 5'(MIN_BITS);
      return 5'(BASE_BITS - int'(req));
   endfunction

endpackage

@@ rtl/core/wavetable_mipmap_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_mipmap_builder
// Wavetable store with halved mip levels, rebuilt by a 1-3-3-1 decimator.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one word per item: kind write (store one base sample),
//    rebuild (regenerate levels 1..N-1 from the level above) or read.
//  - rsp_* returns exactly one word per item: sample_out and level_bits for
//    reads (zero otherwise), done_res = 1 for every valid kind.
//  - All levels live in one 2^(BASE_BITS+1) x 16 single-port-write RAM with
//    a registered read. Write / unknown kind: result registered at accept,
//    1 item per cycle while rsp_ready keeps the result register free. Read:
//    RAM read register, then ST_READ, then the result; no new item meanwhile.
//    Rebuild: builds each level in turn from the level above, with ST_GAP
//    between levels, and answers after the last level; no new item meanwhile.
//  - Rebuild streams the level above through a 4-sample window, one RAM read
//    per cycle, and writes one output per second sample read. ST_GAP between
//    levels lets the last write land before the next level reads it.
//  - Reset clears control only; table contents are undefined until written.
//  - A stalled rsp_ready holds the result register; a new item is taken only
//    once the result register is free or being emptied in that cycle.
// ----------------------------------------------------------------------------
module wavetable_mipmap_builder
   import wmb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [9:0]          req_frame_index,
   input  logic signed [15:0]  req_sample_in,
   input  logic [3:0]          req_level,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_sample_out,
   output logic [4:0]          rsp_level_bits,
   output logic                rsp_done_res
);

   // table RAM
   sample_type mem [STORE_SIZE];
   sample_type q_ff;

   // sequencer
   state_type        state_ff, state_in;
   logic [LV_W-1:0]  lv_ff, lv_in;          // level being built
   logic [CNT_W-1:0] cnt_ff, cnt_in;        // reads issued in this level
   logic [CNT_W-1:0] cnt_d_ff;              // count of the word now in q_ff
   logic             rvld_ff, rvld_in;      // q_ff holds a rebuild word
   sample_type       w0_ff, w1_ff, w2_ff;   // filter window, oldest first
   logic [4:0]       bits_ff, bits_in;      // level_bits held across a read

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_sample_ff, rsp_sample_in;
   logic [4:0]       rsp_bits_ff, rsp_bits_in;
   logic             rsp_done_ff, rsp_done_in;

   // RAM port signals
   logic       we;
   addr_type   wa, ra;
   sample_type wd;

   logic             accept;
   logic             slot_free;
   logic [3:0]       rl;
   logic [3:0]       lv_req;
   logic [3:0]       lv_prev;
   logic [CNT_W-1:0] psz;
   logic [CNT_W-1:0] cnt_dec;
   logic [CNT_W-1:0] half_dec;
   logic signed [SUM_W-1:0] acc;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   assign rl      = read_level(req_level);
   assign lv_req  = 4'(lv_ff);
   assign lv_prev = 4'(lv_ff - 1'b1);
   assign psz     = lvl_size(lv_prev);
   assign cnt_dec = cnt_ff - 1'b1;
   assign half_dec = (cnt_d_ff >> 1) - 1'b1;

   // x[2j-1] + 3x[2j] + 3x[2j+1] + x[2j+2]; floor /8 is the upper bits
   assign acc = SUM_W'(w0_ff) + (SUM_W'(w1_ff) <<< 1) + SUM_W'(w1_ff)
              + (SUM_W'(w2_ff) <<< 1) + SUM_W'(w2_ff) + SUM_W'(q_ff);

   always_comb begin
      state_in      = state_ff;
      lv_in         = lv_ff;
      cnt_in        = cnt_ff;
      rvld_in       = 1'b0;
      bits_in       = bits_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_bits_in   = rsp_bits_ff;
      rsp_done_in   = rsp_done_ff;

      // read address: the request, or the rebuild stream over the level above
      ra = lvl_offset(rl) + (addr_type'(req_frame_index) & addr_type'(lvl_size(rl) - 1'b1));
      if (state_ff == ST_REBUILD) begin
         ra = lvl_offset(lv_prev) + (addr_type'(cnt_dec) & addr_type'(psz - 1'b1));
      end

      // write port: base writes while idle, decimated outputs during rebuild
      we = rvld_ff && cnt_d_ff[0] && (cnt_d_ff >= CNT_W'(3));
      wa = lvl_offset(lv_req) + addr_type'(half_dec);
      wd = acc[SUM_W-1:3];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_WRITE: begin
                     if (addr_type'(req_frame_index) < addr_type'(LEVEL0_SIZE)) begin
                        we = 1'b1;
                     end
                     wa            = addr_type'(req_frame_index);
                     wd            = req_sample_in;
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = '0;
                     rsp_bits_in   = '0;
                     rsp_done_in   = 1'b1;
                  end
                  KIND_REBUILD: begin
                     lv_in  = LV_W'(1);
                     cnt_in = '0;
                     if (NLEVELS > 1) begin
                        state_in = ST_REBUILD;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_sample_in = '0;
                        rsp_bits_in   = '0;
                        rsp_done_in   = 1'b1;
                     end
                  end
                  KIND_READ: begin
                     bits_in  = level_bits(req_level);
                     state_in = ST_READ;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = '0;
                     rsp_bits_in   = '0;
                     rsp_done_in   = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            // slot was freed at accept and nothing else loads it meanwhile
            rsp_valid_in  = 1'b1;
            rsp_sample_in = q_ff;
            rsp_bits_in   = bits_ff;
            rsp_done_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_REBUILD: begin
            rvld_in = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == psz + 1'b1) begin
               cnt_in   = '0;
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            // last write of this level lands now
            if (lv_ff == LV_W'(NLEVELS - 1)) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_sample_in = '0;
               rsp_bits_in   = '0;
               rsp_done_in   = 1'b1;
            end else begin
               lv_in    = lv_ff + 1'b1;
               state_in = ST_REBUILD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      q_ff <= mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lv_ff        <= '0;
         cnt_ff       <= '0;
         rvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lv_ff        <= lv_in;
         cnt_ff       <= cnt_in;
         rvld_ff      <= rvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_d_ff      <= cnt_ff;
      bits_ff       <= bits_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_bits_ff   <= rsp_bits_in;
      rsp_done_ff   <= rsp_done_in;
      if (rvld_ff) begin
         w0_ff <= w1_ff;
         w1_ff <= w2_ff;
         w2_ff <= q_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_level_bits = rsp_bits_ff;
   assign rsp_done_res   = rsp_done_ff;

endmodule

@@ rtl/core/wmb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmb_checker
// Port-level checks for the mipmap builder, bound to the top level.
// ----------------------------------------------------------------------------
module wmb_checker
   import wmb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_sample_out,
   input logic [4:0]         rsp_level_bits,
   input logic               rsp_done_res
);

   logic acc_in;
   assign acc_in = req_valid && req_ready;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_level_bits) && $stable(rsp_done_res))
      else $error("result word changed while stalled");

   // base write answers next cycle with an empty, completed word
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      acc_in && req_kind == KIND_WRITE |=> rsp_valid && rsp_done_res
         && rsp_sample_out == 16'sd0 && rsp_level_bits == 5'd0)
      else $error("write result missing or wrong");

   // unknown kind answers next cycle, not done
   a_none_rsp: assert property (@(posedge clock) disable iff (reset)
      acc_in && req_kind == KIND_NONE |=> rsp_valid && !rsp_done_res)
      else $error("unknown-kind result missing or wrong");

   // read: port not ready while in ST_READ, then a completed result word
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      acc_in && req_kind == KIND_READ |=> !req_ready ##1 rsp_valid && rsp_done_res)
      else $error("read result timing wrong");

endmodule

bind wavetable_mipmap_builder wmb_checker u_wmb_checker (.*);
